/* src/token_bucket_bit_rate_shaper_macros.svh */
// Assertion macros shared by the token bucket shaper RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef TOKEN_BUCKET_BIT_RATE_SHAPER_MACROS_SVH
`define TOKEN_BUCKET_BIT_RATE_SHAPER_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define TBBRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tbbrs assertion failed");
// Check that a condition never holds on a rising edge outside reset.
`define TBBRS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (!(cond))) \
    else $error("tbbrs forbidden condition seen");
`else
`define TBBRS_ASSERT(lbl, clk, rstn, prop)
`define TBBRS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* src/tbbrs_pkg.sv */
// Shared types and constants of the token bucket bit-rate shaper.
// No dependencies; used by the channel interfaces and all RTL modules.
package tbbrs_pkg;

  // Field widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TICK_W     = 64;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned CREDIT_W   = 64;
  localparam int unsigned ELAPSED_W  = 32;
  // Largest positive credit is max_rate * 1000 millibits, below 2^42
  localparam int unsigned DIVIDEND_W = 42;

  // Millibits per bit
  localparam logic [9:0] MILLI = 10'd1000;

  // Divide by 1000 as a shift by 3 and an exact divide by 125
  localparam int unsigned PRE_SHIFT    = 3;
  localparam logic [6:0]  DIV_ODD      = 7'd125;
  localparam int unsigned LO_DIGIT_W   = 20;
  localparam int unsigned HI_DIGIT_W   = DIVIDEND_W - PRE_SHIFT - LO_DIGIT_W;
  localparam int unsigned RECIP_HI_SH  = 26;
  localparam logic [19:0] RECIP_HI     = 20'd536871;
  localparam int unsigned RECIP_LO_SH  = 34;
  localparam logic [27:0] RECIP_LO     = 28'd137438954;

  localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY   = 2'd0,
    MODE_CONSUME = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

endpackage

/* src/tbbrs_req_if.sv */
// Request channel of the shaper: valid/ready plus one request item.
// Depends on tbbrs_pkg for the field widths.
interface tbbrs_req_if import tbbrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TICK_W-1:0] now_ms;
  logic [RATE_W-1:0] consume_bits;

  modport source (output valid, output mode, output now_ms, output consume_bits,
                  input ready);
  modport sink   (input valid, input mode, input now_ms, input consume_bits,
                  output ready);
endinterface

/* src/tbbrs_rsp_if.sv */
// Response channel of the shaper: valid/ready plus the available bit count.
// Depends on tbbrs_pkg for the field width.
interface tbbrs_rsp_if import tbbrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] available_bits;

  modport source (output valid, output available_bits, input ready);
  modport sink   (input valid, input available_bits, output ready);
endinterface

/* src/tbbrs_div1000.sv */
// Two-stage pipelined divide of the positive credit by 1000 (millibits to bits).
// Depends on tbbrs_pkg and the shaper assertion macros.
`include "token_bucket_bit_rate_shaper_macros.svh"

module tbbrs_div1000 import tbbrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [RATE_W-1:0]     quotient_o
);

  localparam int unsigned REM_W     = 7;
  localparam int unsigned QH_W      = HI_DIGIT_W - REM_W + 1;
  localparam int unsigned HI_PROD_W = HI_DIGIT_W + 20;
  localparam int unsigned LOW_W     = REM_W + LO_DIGIT_W;
  localparam int unsigned LO_PROD_W = LOW_W + 28;

  logic [HI_DIGIT_W-1:0] xh;
  logic [LO_DIGIT_W-1:0] xl;
  logic [HI_PROD_W-1:0]  prod_hi;
  logic [QH_W-1:0]       qh;
  logic [HI_DIGIT_W-1:0] rem_full;
  logic [LOW_W-1:0]      low_d;
  logic [LO_PROD_W-1:0]  prod_lo;
  logic [LO_DIGIT_W-1:0] ql;
  logic [RATE_W-1:0]     quot_d;
  logic [LOW_W-1:0]      lo_back;
  logic [LOW_W-1:0]      lo_rem;

  logic                  v1_q;
  logic [QH_W-1:0]       qh_q;
  logic [LOW_W-1:0]      low_q;
  logic                  vo_q;
  logic [RATE_W-1:0]     quot_q;
  logic                  ready_o_stage;
  logic                  ready_1_stage;

  // High digit: floor(xh / 125) by reciprocal, remainder by multiply and subtract
  assign xh       = dividend_i[DIVIDEND_W-1 -: HI_DIGIT_W];
  assign xl       = dividend_i[PRE_SHIFT +: LO_DIGIT_W];
  assign prod_hi  = HI_PROD_W'(xh) * HI_PROD_W'(RECIP_HI);
  assign qh       = prod_hi[RECIP_HI_SH +: QH_W];
  assign rem_full = xh - HI_DIGIT_W'(HI_DIGIT_W'(qh) * HI_DIGIT_W'(DIV_ODD));
  assign low_d    = {rem_full[REM_W-1:0], xl};

  // Low digit: floor(low / 125) by reciprocal, then join the digits
  assign prod_lo = LO_PROD_W'(low_q) * LO_PROD_W'(RECIP_LO);
  assign ql      = prod_lo[RECIP_LO_SH +: LO_DIGIT_W];
  assign quot_d  = RATE_W'({qh_q, ql});

  // Low digit times the divisor and what is left over
  assign lo_back = LOW_W'(LOW_W'(ql) * LOW_W'(DIV_ODD));
  assign lo_rem  = low_q - lo_back;

  // Each stage loads when empty or when its content moves on
  assign ready_o_stage = !vo_q || out_ready_i;
  assign ready_1_stage = !v1_q || ready_o_stage;
  assign in_ready_o    = ready_1_stage;
  assign out_valid_o   = vo_q;
  assign quotient_o    = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ready_1_stage) begin
        v1_q <= in_valid_i;
      end
      if (ready_o_stage) begin
        vo_q <= v1_q;
      end
    end
  end

  // Payload stages, no reset
  always_ff @(posedge clk_i) begin
    if (ready_1_stage && in_valid_i) begin
      qh_q  <= qh;
      low_q <= low_d;
    end
    if (ready_o_stage && v1_q) begin
      quot_q <= quot_d;
    end
  end

  `TBBRS_ASSERT_NEVER(a_hi_rem_range, clk_i, rst_ni, in_valid_i && (rem_full >= HI_DIGIT_W'(DIV_ODD)))
  `TBBRS_ASSERT(a_lo_digit_exact, clk_i, rst_ni, v1_q |-> ((lo_back <= low_q) && (lo_rem < LOW_W'(DIV_ODD))))
  `TBBRS_ASSERT(a_out_from_stage1, clk_i, rst_ni, $rose(vo_q) |-> $past(v1_q))

endmodule

/* src/token_bucket_bit_rate_shaper.sv */
// Top level of the token bucket bit-rate shaper: credit update and handshakes.
// Depends on tbbrs_pkg, tbbrs_req_if, tbbrs_rsp_if, tbbrs_div1000 and the macros.
//
// The shaper keeps a signed 64-bit credit in millibits that grows by max_rate
// millibits per elapsed millisecond and on a later query is clamped to plus or
// minus one second of rate. A query (mode 0) returns the whole bits of positive
// credit; consume (mode 1) and restart (mode 2) return nothing, mode 3 is
// ignored. One request is taken per clock cycle while the response side keeps
// up. A query result passes through the request register, where the credit loop
// (a 32x32 multiply of rate by elapsed time, an add and the clamp) updates the
// bucket, the divider feed register and the first stage of the pipelined divide
// by 1000, whose second stage holds the result. The user must write max_rate
// through cfg_we_i/cfg_wdata_i only while no request is in flight; the block
// itself does not enforce this.
`include "token_bucket_bit_rate_shaper_macros.svh"

module token_bucket_bit_rate_shaper import tbbrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  tbbrs_req_if.sink         req_i,
  tbbrs_rsp_if.source       rsp_o
);

  logic [RATE_W-1:0]           max_rate_q;

  // Request register
  logic                        v1_q;
  logic [MODE_W-1:0]           mode_q;
  logic [ELAPSED_W-1:0]        now_q;
  logic [RATE_W-1:0]           bits_q;

  // Bucket state
  logic signed [CREDIT_W-1:0]  credit_q;
  logic signed [CREDIT_W-1:0]  credit_d;
  logic                        started_q;
  logic                        started_d;
  logic [ELAPSED_W-1:0]        last_q;
  logic [ELAPSED_W-1:0]        last_d;

  // Divider feed register
  logic                        v2_q;
  logic [DIVIDEND_W-1:0]       dividend_q;
  logic [DIVIDEND_W-1:0]       dividend_d;

  logic                        emit;
  logic                        fire1;
  logic                        ready1;
  logic                        ready2;
  logic                        div_ready;
  logic                        is_query;
  logic                        is_consume;
  logic                        is_restart;

  logic [DIVIDEND_W-1:0]       hi;
  logic signed [CREDIT_W-1:0]  hi_s;
  logic signed [CREDIT_W-1:0]  neg_hi;
  logic [ELAPSED_W-1:0]        elapsed;
  logic [CREDIT_W-1:0]         add;
  logic                        c_above;
  logic [CREDIT_W:0]           room;
  logic                        add_ge;
  logic [CREDIT_W-1:0]         sum_u;
  logic signed [CREDIT_W-1:0]  q_clip;
  logic signed [CREDIT_W-1:0]  q_credit;
  logic signed [CREDIT_W-1:0]  first_credit;
  logic [DIVIDEND_W-1:0]       amount;
  logic [CREDIT_W:0]           diff;
  logic signed [CREDIT_W-1:0]  cons_credit;

  logic                        fire_restart;
  logic                        fire_refill;
  logic                        fire_first;
  logic                        fire_consume;
  logic                        credit_in_clamp;

  assign is_query   = mode_e'(mode_q) == MODE_QUERY;
  assign is_consume = mode_e'(mode_q) == MODE_CONSUME;
  assign is_restart = mode_e'(mode_q) == MODE_RESTART;

  // Refill on a query: add rate * elapsed, clamp to +-rate*1000
  assign hi      = DIVIDEND_W'(max_rate_q) * DIVIDEND_W'(MILLI);
  assign hi_s    = $signed(CREDIT_W'(hi));
  assign neg_hi  = -hi_s;
  assign elapsed = now_q - last_q;
  assign add     = CREDIT_W'(max_rate_q) * CREDIT_W'(elapsed);
  assign c_above = credit_q > hi_s;
  assign room    = {1'b0, $unsigned(hi_s)} - {credit_q[CREDIT_W-1], $unsigned(credit_q)};
  assign add_ge  = {1'b0, add} >= room;
  assign sum_u   = $unsigned(credit_q) + add;
  assign q_clip  = (c_above || add_ge) ? hi_s : $signed(sum_u);
  assign q_credit = (q_clip < neg_hi) ? neg_hi : q_clip;

  // First query loads rate millibits, unclamped
  assign first_credit = $signed(CREDIT_W'(max_rate_q));

  // Drain on a consume, saturating at the most negative credit
  assign amount      = DIVIDEND_W'(bits_q) * DIVIDEND_W'(MILLI);
  assign diff        = {credit_q[CREDIT_W-1], $unsigned(credit_q)} - (CREDIT_W + 1)'(amount);
  assign cons_credit = (diff[CREDIT_W] ^ diff[CREDIT_W-1]) ? CREDIT_MIN
                                                           : $signed(diff[CREDIT_W-1:0]);

  // Next bucket state for the request in the register
  always_comb begin
    credit_d  = credit_q;
    started_d = started_q;
    last_d    = last_q;
    emit      = 1'b0;
    case (mode_e'(mode_q))
      MODE_QUERY: begin
        emit      = 1'b1;
        started_d = 1'b1;
        last_d    = now_q;
        credit_d  = started_q ? q_credit : first_credit;
      end
      MODE_CONSUME: begin
        credit_d = cons_credit;
      end
      MODE_RESTART: begin
        credit_d  = '0;
        started_d = 1'b0;
        last_d    = '0;
      end
      default: begin
      end
    endcase
  end

  // Only positive credit reaches the divider
  assign dividend_d = (!credit_d[CREDIT_W-1] && (credit_d != '0))
                      ? credit_d[DIVIDEND_W-1:0] : '0;

  // Handshake chain: a query leaves the register when its result has room; other requests leave without waiting
  assign ready2      = !v2_q || div_ready;
  assign fire1       = v1_q && (!emit || ready2);
  assign ready1      = !v1_q || fire1;
  assign req_i.ready = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      credit_q   <= '0;
      started_q  <= 1'b0;
      last_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        max_rate_q <= cfg_wdata_i;
      end
      if (ready1) begin
        v1_q <= req_i.valid;
      end
      if (ready2) begin
        v2_q <= fire1 && emit;
      end
      if (fire1) begin
        credit_q  <= credit_d;
        started_q <= started_d;
        last_q    <= last_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (ready1 && req_i.valid) begin
      mode_q <= req_i.mode;
      now_q  <= req_i.now_ms[ELAPSED_W-1:0];
      bits_q <= req_i.consume_bits;
    end
    if (fire1 && emit) begin
      dividend_q <= dividend_d;
    end
  end

  tbbrs_div1000 u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (div_ready),
    .dividend_i  (dividend_q),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .quotient_o  (rsp_o.available_bits)
  );

  // Transfers out of the request register, by kind
  assign fire_restart    = fire1 && is_restart;
  assign fire_refill     = fire1 && is_query && started_q;
  assign fire_first      = fire1 && is_query && !started_q;
  assign fire_consume    = fire1 && is_consume;
  assign credit_in_clamp = (credit_q <= hi_s) && (credit_q >= neg_hi);

  `TBBRS_ASSERT(a_restart_clears, clk_i, rst_ni, fire_restart |=> (!started_q && (credit_q == '0)))
  `TBBRS_ASSERT(a_query_clamped, clk_i, rst_ni, fire_refill |=> credit_in_clamp)
  `TBBRS_ASSERT(a_first_query, clk_i, rst_ni, fire_first |=> (started_q && (credit_q == first_credit)))
  `TBBRS_ASSERT(a_consume_drains, clk_i, rst_ni, fire_consume |=> (credit_q <= $past(credit_q)))

endmodule

/* bench/token_bucket_bit_rate_shaper_test.sv */
// Self-checking bench for the token bucket bit-rate shaper: directed and random
// queries, consumes and restarts, with random stalls on both channels.
// Depends on tbbrs_pkg, tbbrs_req_if, tbbrs_rsp_if and the shaper RTL.
module token_bucket_bit_rate_shaper_test;
  import tbbrs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 130;
  localparam int RX_HOLD_CYCLES = 150;

  // Track the bucket and queue the available-bit counts each query must return
  class credit_tracker;
    logic [RATE_W-1:0]          rate_bps;
    logic signed [CREDIT_W-1:0] credit_mb;
    bit                         primed;
    logic [TICK_W-1:0]          prev_ms;
    logic [RATE_W-1:0]          avail_due[$];
    int                         errors;
    int                         checked;

    function new();
      rate_bps  = '0;
      credit_mb = '0;
      primed    = 1'b0;
      prev_ms   = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    // Whole bits of positive credit
    function logic [RATE_W-1:0] whole_bits();
      logic signed [CREDIT_W-1:0] q;
      if (credit_mb <= 0) return '0;
      q = credit_mb / 64'sd1000;
      return q[RATE_W-1:0];
    endfunction

    // Apply one accepted request to the bucket
    function void take_request(logic [MODE_W-1:0] mode, logic [TICK_W-1:0] now,
                               logic [RATE_W-1:0] bits);
      logic signed [CREDIT_W-1:0] hi;
      logic signed [CREDIT_W-1:0] c;
      logic signed [CREDIT_W-1:0] amount;
      logic [CREDIT_W-1:0]        elapsed;
      logic [CREDIT_W-1:0]        add_mb;
      logic [CREDIT_W-1:0]        room;
      case (mode)
        MODE_QUERY: begin
          if (!primed) begin
            credit_mb = $signed({32'd0, rate_bps});
            primed = 1'b1;
          end else begin
            hi = $signed({32'd0, rate_bps}) * 64'sd1000;
            elapsed = {32'd0, now[31:0] - prev_ms[31:0]};
            add_mb = {32'd0, rate_bps} * elapsed;
            c = credit_mb;
            if (c > hi) begin
              c = hi;
            end else begin
              room = hi - c;
              if (add_mb >= room) c = hi;
              else c = c + add_mb;
            end
            if (c < -hi) c = -hi;
            credit_mb = c;
          end
          prev_ms = now;
          avail_due.push_back(whole_bits());
        end
        MODE_CONSUME: begin
          amount = $signed({32'd0, bits} * 64'd1000);
          if (credit_mb < CREDIT_MIN + amount) credit_mb = CREDIT_MIN;
          else credit_mb = credit_mb - amount;
        end
        MODE_RESTART: begin
          credit_mb = '0;
          primed    = 1'b0;
          prev_ms   = '0;
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one response transfer with the oldest queued count
    task check_avail(logic [RATE_W-1:0] got);
      logic [RATE_W-1:0] want;
      if (avail_due.size() == 0) begin
        flag_mismatch($sformatf("response %0d with no query waiting", got));
      end else begin
        want = avail_due.pop_front();
        checked++;
        if (got !== want)
          flag_mismatch($sformatf("available_bits %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [RATE_W-1:0] cfg_wdata_i;

  tbbrs_req_if req_if ();
  tbbrs_rsp_if rsp_if ();

  token_bucket_bit_rate_shaper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  credit_tracker     bucket;
  bit                tx_eager;
  bit                rx_eager;
  int                rx_hold_req;
  int                rx_holds;
  int                cycle_count;
  int                n_query;
  int                n_consume;
  int                n_restart;
  int                n_unused;
  int                n_rates;
  logic [TICK_W-1:0] clock_ms;

  // Free-running clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d responses outstanding", bucket.avail_due.size());
      $display("FAIL token_bucket_bit_rate_shaper");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_req(logic [MODE_W-1:0] mode, logic [TICK_W-1:0] now,
                          logic [RATE_W-1:0] bits);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid        <= 1'b0;
      req_if.mode         <= MODE_W'($urandom);
      req_if.now_ms       <= {$urandom, $urandom};
      req_if.consume_bits <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= mode;
    req_if.now_ms       <= now;
    req_if.consume_bits <= bits;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    bucket.take_request(mode, now, bits);
    case (mode)
      MODE_QUERY:   n_query++;
      MODE_CONSUME: n_consume++;
      MODE_RESTART: n_restart++;
      default:      n_unused++;
    endcase
  endtask

  // Drop valid, wait for every response, then let the pipeline empty
  task automatic settle();
    req_if.valid <= 1'b0;
    while (bucket.avail_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] rate);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bucket.rate_bps = rate;
    n_rates++;
  endtask

  // Mostly queries on a slowly advancing tick and consumes near the rate scale
  task automatic random_req();
    int                pick;
    int unsigned       scale;
    logic [RATE_W-1:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_req(MODE_RESTART, {$urandom, $urandom}, $urandom);
    end else if (pick < 5) begin
      send_req(MODE_UNUSED, {$urandom, $urandom}, $urandom);
    end else if (pick < 40) begin
      scale = bucket.rate_bps / 1000;
      pick = $urandom_range(0, 99);
      if (pick < 60) bits = $urandom_range(0, scale * 2 + 10);
      else if (pick < 85) bits = $urandom;
      else bits = $urandom_range(0, 3);
      send_req(MODE_CONSUME, {$urandom, $urandom}, bits);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) clock_ms = clock_ms + $urandom_range(0, 20);
      else if (pick < 80) clock_ms = clock_ms + $urandom_range(0, 2000);
      else if (pick < 87) clock_ms = clock_ms - $urandom_range(1, 500);
      else if (pick < 94) clock_ms = {$urandom, $urandom};
      else clock_ms = clock_ms + {32'd0, $urandom};
      send_req(MODE_QUERY, clock_ms, $urandom);
    end
  endtask

  // Response side: random stalls, an occasional long hold-off
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
        rx_holds++;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      bucket.check_avail(rsp_if.available_bits);
    end
  end

  initial begin
    logic [RATE_W-1:0] phase_rate[10];
    int                counted;
    bucket      = new();
    tx_eager    = 1'b0;
    rx_eager    = 1'b0;
    rx_hold_req = 0;
    rx_holds    = 0;
    n_query     = 0;
    n_consume   = 0;
    n_restart   = 0;
    n_unused    = 0;
    n_rates     = 0;
    clock_ms    = '0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.mode         <= '0;
    req_if.now_ms       <= '0;
    req_if.consume_bits <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero rate out of reset: first query at tick zero, clamp to zero credit
    send_req(MODE_QUERY, 64'd0, 32'd0);
    send_req(MODE_QUERY, '1, 32'd0);
    send_req(MODE_CONSUME, 64'd0, '1);
    send_req(MODE_QUERY, 64'd5, 32'd0);
    send_req(MODE_UNUSED, '1, '1);

    // Top rate: saturating add, tick going back, negative clamp
    write_rate('1);
    send_req(MODE_RESTART, '1, '1);
    send_req(MODE_QUERY, 64'd0, 32'd0);
    send_req(MODE_QUERY, '1, 32'd0);
    send_req(MODE_QUERY, 64'd5, 32'd0);
    send_req(MODE_CONSUME, 64'd0, '1);
    send_req(MODE_CONSUME, 64'd0, '1);
    send_req(MODE_QUERY, 64'd5, 32'd0);
    send_req(MODE_CONSUME, 64'd0, '1);
    send_req(MODE_QUERY, 64'd5, 32'd0);
    send_req(MODE_QUERY, 64'd1005, 32'd0);
    send_req(MODE_QUERY, 64'd2005, 32'd0);

    // Rate lowered under a full bucket, then restart and a fresh first query
    write_rate(32'd1);
    send_req(MODE_QUERY, 64'd2005, 32'd0);
    send_req(MODE_CONSUME, 64'd0, 32'd0);
    send_req(MODE_RESTART, 64'd0, 32'd0);
    send_req(MODE_QUERY, 64'd12345, 32'd0);
    send_req(MODE_QUERY, 64'd13344, 32'd0);
    send_req(MODE_UNUSED, 64'd0, 32'd0);
    write_rate(32'd1000);
    send_req(MODE_QUERY, 64'd13347, 32'd0);
    send_req(MODE_CONSUME, 64'd0, 32'd1);
    send_req(MODE_QUERY, 64'd13347, 32'd0);

    // Random phases, one rate setting each
    phase_rate[0] = 32'd0;
    phase_rate[1] = 32'd1;
    phase_rate[2] = 32'd999;
    phase_rate[3] = 32'd1000;
    phase_rate[4] = '1;
    phase_rate[5] = $urandom;
    phase_rate[6] = $urandom_range(1, 100000);
    phase_rate[7] = 32'h8000_0000;
    phase_rate[8] = '1;
    phase_rate[9] = 32'd12345;
    clock_ms = 64'd13347;
    for (int p = 0; p < 10; p++) begin
      write_rate(phase_rate[p]);
      tx_eager = (p % 4 == 2) || (p == 3) || (p == 7);
      rx_eager = (p % 4 == 2);
      if (p == 3 || p == 7) rx_hold_req = RX_HOLD_CYCLES;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        random_req();
        if (req_if.mode != MODE_UNUSED) counted++;
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    settle();

    $display("covered %0d queries, %0d consumes, %0d restarts, %0d ignored items",
             n_query, n_consume, n_restart, n_unused);
    $display("over %0d rate settings; %0d responses checked, %0d long hold-offs",
             n_rates, bucket.checked, rx_holds);
    if (bucket.errors == 0) begin
      $display("PASS token_bucket_bit_rate_shaper");
    end else begin
      $display("FAIL token_bucket_bit_rate_shaper");
    end
    $finish;
  end

endmodule
